### design/ile_pkg.sv
// shared types and codes for the indexed list engine
`default_nettype none

package ile_pkg;

  // field widths fixed by the command and result formats
  localparam int unsigned IDX_W = 9;
  localparam int unsigned VAL_W = 32;
  // position width inside the cell row, wide enough for the largest list (4096 entries)
  localparam int unsigned POS_W = 13;

  // command codes
  localparam logic [3:0] ACT_APPEND     = 4'd0;
  localparam logic [3:0] ACT_PREPEND    = 4'd1;
  localparam logic [3:0] ACT_DROP_FIRST = 4'd2;
  localparam logic [3:0] ACT_DROP_LAST  = 4'd3;
  localparam logic [3:0] ACT_GET        = 4'd4;
  localparam logic [3:0] ACT_SET        = 4'd5;
  localparam logic [3:0] ACT_INSERT     = 4'd6;
  localparam logic [3:0] ACT_DELETE     = 4'd7;
  localparam logic [3:0] ACT_REVERSE    = 4'd8;

  // status codes
  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_REJECT = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  // operation carried by the token that walks the cell row
  typedef enum logic [2:0] {
    OP_NOP,
    OP_INS,
    OP_DEL,
    OP_SET,
    OP_GET
  } ile_op_e;

  // command transaction
  typedef struct packed {
    logic [3:0]              action;
    logic [IDX_W-1:0]        index;
    logic signed [VAL_W-1:0] value;
  } ile_in_t;

  // result transaction
  typedef struct packed {
    logic [1:0]              status;
    logic signed [VAL_W-1:0] read_value;
    logic [IDX_W-1:0]        entry_count;
    logic signed [VAL_W-1:0] head_value;
    logic signed [VAL_W-1:0] tail_value;
  } ile_out_t;

  // token handed from cell to cell
  typedef struct packed {
    logic             vld;
    ile_op_e          op;
    logic [POS_W-1:0] pos;       // physical cell the command targets
    logic [POS_W-1:0] last_pos;  // physical cell of the last entry after the command
    logic [VAL_W-1:0] carry;     // value to write, then the displaced value on insert
    logic [VAL_W-1:0] rd;        // value picked up by get
    logic [VAL_W-1:0] lo;        // final content of cell 0
    logic [VAL_W-1:0] hi;        // final content of the last occupied cell
  } ile_tok_t;

endpackage

`default_nettype wire

### design/indexed_list_engine.sv
// indexed list engine top level: command decode, cell row and result buffering
`default_nettype none

// Ordered list of up to MAX_ENTRIES signed 32-bit values held in a row of cells,
// one entry per cell. A command is decoded when accepted and sent down the row as
// a token that moves one cell per cycle; each cell shifts, writes or reads its
// entry as the token passes and the token collects the read value and both ends
// of the list. The token passes every cell of the row and the result is then
// registered at the output, or in the pending slot while the output is held. One
// command is in the row at a time, so a new command is not taken until the token
// of the last one has left the row and the pending slot is free. Reverse only
// flips the read direction of the row and so costs no more than any other
// command. A finished result may wait at the output while the next command is already accepted.
module indexed_list_engine import ile_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = 256
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_stall_o,
  input  wire ile_in_t in_data_i,
  output logic         out_valid_o,
  input  wire logic    out_stall_i,
  output ile_out_t     out_data_o
);

  localparam int unsigned CntW = $clog2(MAX_ENTRIES + 1);

  // front end state
  logic [CntW-1:0] count_q, count_d;
  logic            flip_q, flip_d;
  logic            busy_q;
  logic [1:0]      status_q, status_d;
  ile_tok_t        ent_q, ent_d;

  // result buffering
  ile_out_t        out_q, pend_q, res;
  logic            out_vld_q, pend_vld_q;

  // cell row wiring
  ile_tok_t         row_tok  [MAX_ENTRIES+1];
  logic [VAL_W-1:0] row_data [MAX_ENTRIES+1];
  ile_tok_t         tok_end;

  logic             in_acc, out_take, out_free;
  logic [POS_W-1:0] cnt_w, idx_w, last_w;
  logic             full, empty;

  assign in_stall_o = busy_q || pend_vld_q;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_take   = out_vld_q && !out_stall_i;
  assign out_free   = !out_vld_q || out_take;

  // command decode into a physical cell operation
  always_comb begin
    cnt_w    = POS_W'(count_q);
    idx_w    = POS_W'(in_data_i.index);
    full     = (count_q == CntW'(MAX_ENTRIES));
    empty    = (count_q == '0);
    count_d  = count_q;
    flip_d   = flip_q;
    status_d = ST_DONE;
    ent_d       = '0;
    ent_d.vld   = 1'b1;
    ent_d.op    = OP_NOP;
    ent_d.carry = in_data_i.value;
    unique case (in_data_i.action)
      ACT_APPEND: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          ent_d.op  = OP_INS;
          ent_d.pos = flip_q ? '0 : cnt_w;
          count_d   = count_q + 1'b1;
        end
      end
      ACT_PREPEND: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          ent_d.op  = OP_INS;
          ent_d.pos = flip_q ? cnt_w : '0;
          count_d   = count_q + 1'b1;
        end
      end
      ACT_DROP_FIRST: begin
        if (empty) begin
          status_d = ST_REJECT;
        end else begin
          ent_d.op  = OP_DEL;
          ent_d.pos = flip_q ? cnt_w - 1'b1 : '0;
          count_d   = count_q - 1'b1;
        end
      end
      ACT_DROP_LAST: begin
        if (empty) begin
          status_d = ST_REJECT;
        end else begin
          ent_d.op  = OP_DEL;
          ent_d.pos = flip_q ? '0 : cnt_w - 1'b1;
          count_d   = count_q - 1'b1;
        end
      end
      ACT_GET: begin
        if (idx_w >= cnt_w) begin
          status_d = ST_REJECT;
        end else begin
          ent_d.op  = OP_GET;
          ent_d.pos = flip_q ? cnt_w - 1'b1 - idx_w : idx_w;
        end
      end
      ACT_SET: begin
        if (idx_w >= cnt_w) begin
          status_d = ST_REJECT;
        end else begin
          ent_d.op  = OP_SET;
          ent_d.pos = flip_q ? cnt_w - 1'b1 - idx_w : idx_w;
        end
      end
      ACT_INSERT: begin
        if (idx_w > cnt_w) begin
          status_d = ST_REJECT;
        end else if (full) begin
          status_d = ST_FULL;
        end else begin
          ent_d.op  = OP_INS;
          ent_d.pos = flip_q ? cnt_w - idx_w : idx_w;
          count_d   = count_q + 1'b1;
        end
      end
      ACT_DELETE: begin
        if (idx_w >= cnt_w) begin
          status_d = ST_REJECT;
        end else begin
          ent_d.op  = OP_DEL;
          ent_d.pos = flip_q ? cnt_w - 1'b1 - idx_w : idx_w;
          count_d   = count_q - 1'b1;
        end
      end
      ACT_REVERSE: begin
        flip_d = !flip_q;
      end
      default: begin
        status_d = ST_REJECT;
      end
    endcase
    ent_d.last_pos = POS_W'(count_d) - 1'b1;
  end

  // front end registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      flip_q   <= 1'b0;
      busy_q   <= 1'b0;
      status_q <= ST_DONE;
      ent_q    <= '0;
    end else begin
      if (in_acc) begin
        count_q  <= count_d;
        flip_q   <= flip_d;
        status_q <= status_d;
        ent_q    <= ent_d;
        busy_q   <= 1'b1;
      end else begin
        ent_q.vld <= 1'b0;
        if (tok_end.vld) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // row of cells, token enters at cell 0
  assign row_tok[0]             = ent_q;
  assign row_data[MAX_ENTRIES]  = '0;

  for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_cell
    ile_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .pos_i  (POS_W'(k)),
      .tok_i  (row_tok[k]),
      .next_i (row_data[k+1]),
      .tok_o  (row_tok[k+1]),
      .data_o (row_data[k])
    );
  end

  assign tok_end = row_tok[MAX_ENTRIES];

  // result assembly, count and direction already hold the post-command values
  always_comb begin
    res.status      = status_q;
    res.read_value  = tok_end.rd;
    res.entry_count = cnt_w[IDX_W-1:0];
    if (empty) begin
      res.head_value = '0;
      res.tail_value = '0;
    end else begin
      res.head_value = flip_q ? tok_end.hi : tok_end.lo;
      res.tail_value = flip_q ? tok_end.lo : tok_end.hi;
    end
  end

  // output register with one pending slot behind it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      pend_vld_q <= 1'b0;
      out_q      <= '0;
      pend_q     <= '0;
    end else begin
      if (tok_end.vld) begin
        if (out_free) begin
          out_q     <= res;
          out_vld_q <= 1'b1;
        end else begin
          pend_q     <= res;
          pend_vld_q <= 1'b1;
        end
      end else if (pend_vld_q && out_free) begin
        out_q      <= pend_q;
        out_vld_q  <= 1'b1;
        pend_vld_q <= 1'b0;
      end else if (out_take) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  // a token leaves the row only while a command is outstanding
  a_tok_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_end.vld |-> busy_q)
    else $error("token left the cell row with no command outstanding");

  // an accepted command keeps the engine busy until its token returns
  a_acc_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> busy_q)
    else $error("engine not busy after accepting a command");

  // entry count stays within the row
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MAX_ENTRIES))
    else $error("entry count beyond list capacity");

  // the pending slot is only used behind a held output
  a_pend_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_vld_q |-> out_vld_q)
    else $error("pending result without a result at the output");
`endif

endmodule

`default_nettype wire

### design/ile_cell.sv
// one storage cell of the list row with its token stage
`default_nettype none

module ile_cell import ile_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [POS_W-1:0] pos_i,
  input  wire ile_tok_t         tok_i,
  input  wire logic [VAL_W-1:0] next_i,
  output ile_tok_t              tok_o,
  output logic [VAL_W-1:0]      data_o
);

  logic [VAL_W-1:0] data_q, data_d;
  ile_tok_t         tok_q, tok_d;
  logic             at_pos, past_pos, in_range;

  // local update as the token passes
  always_comb begin
    at_pos   = (pos_i == tok_i.pos);
    past_pos = (pos_i > tok_i.pos);
    in_range = (pos_i <= tok_i.last_pos);
    tok_d    = tok_i;
    data_d   = data_q;
    if (tok_i.vld) begin
      unique case (tok_i.op)
        OP_INS: begin
          // take the value from the left, hand the old one on
          if ((at_pos || past_pos) && in_range) begin
            data_d      = tok_i.carry;
            tok_d.carry = data_q;
          end
        end
        OP_DEL: begin
          // neighbour on the right has not been visited yet
          if ((at_pos || past_pos) && in_range) begin
            data_d = next_i;
          end
        end
        OP_SET: begin
          if (at_pos) begin
            data_d = tok_i.carry;
          end
        end
        OP_GET: begin
          if (at_pos) begin
            tok_d.rd = data_q;
          end
        end
        OP_NOP: begin
        end
        default: begin
        end
      endcase
    end
    // collect the ends of the list on the way past
    if (pos_i == '0) begin
      tok_d.lo = data_d;
    end
    if (pos_i == tok_i.last_pos) begin
      tok_d.hi = data_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  // token stage towards the next cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o  = tok_q;
  assign data_o = data_q;

endmodule

`default_nettype wire
